@@ design/windowed_peak_rms_level_history_assert.svh @@
// assertion macros for the level history block
// depends on i_clk and i_rst_n in the including module
`ifndef WINDOWED_PEAK_RMS_LEVEL_HISTORY_ASSERT_SVH
`define WINDOWED_PEAK_RMS_LEVEL_HISTORY_ASSERT_SVH

// same-cycle implication check
`define WPRL_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wprl check failed");

// next-cycle implication check
`define WPRL_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wprl check failed");

`endif

@@ design/wprl_pkg.sv @@
// shared types, constants and tables of the level history block
// no dependencies
`timescale 1ns / 1ps
package wprl_pkg;

    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int MAX_CHANNELS_DEF  = 8;
    localparam int LANES             = 8;

    localparam logic signed [14:0] LEVEL_FLOOR = -15'sd16000;
    localparam logic signed [14:0] LEVEL_CEIL  = 15'sd960;
    localparam logic signed [34:0] LOG2_TEN_Q24 = 35'sd348329;
    localparam logic signed [45:0] DB16_Q16     = 46'sd3156528;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_QMAX   = 2'd1,
        ACT_QRMS   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE, S_TREAD, S_TDATA, S_LREAD, S_LDATA, S_EXP, S_SHIFT,
        S_RES, S_DIV, S_NORM, S_LOG, S_MUL, S_FIN, S_OWAIT
    } t_state;

    // q30 factors 2^(2^-(i+1))
    function automatic logic [30:0] exp_frac(input logic [3:0] i);
        logic [30:0] v;
        unique case (i)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170923762;
            4'd3:    v = 31'd1121280435;
            4'd4:    v = 31'd1097253708;
            4'd5:    v = 31'd1085434106;
            4'd6:    v = 31'd1079572136;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468888;
            default: v = 31'd1073741824;
        endcase
        return v;
    endfunction

endpackage

@@ design/wprl_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module wprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/windowed_peak_rms_level_history.sv @@
// top level of the windowed peak / rms level history
// depends on wprl_pkg, wprl_ram and windowed_peak_rms_level_history_assert.svh
`timescale 1ns / 1ps
// Usage
//  Input channel (i_valid/o_ready) takes requests: append a channel level, or
//  query max / rms level since a timestamp. Output channel (o_valid/i_ready)
//  returns one result per active channel, o_last on the final one.
//  i_cfg_we/i_cfg_wdata write the channel count and clear the history.
// Operation
//  An append is taken in the idle state; the next request may follow directly.
//  A query holds the input side until its last result is taken. The walk
//  reads per row a time word and per channel a level, then runs a 10 step
//  power expansion through one 31x31 multiplier and an accumulate. Each rms
//  result then passes a restoring divider, a normalize shift, 16 log
//  squarings, a multiply and a clamp; a max result is clamped straight
//  into the output register.
// Reset
//  Synchronous reset empties the history and sets the channel count to 0;
//  the level and time memories are not cleared and need no clearing pass.
// Stall
//  A result waits in the output register while i_ready is low; the next
//  result is not started until it is taken.
module windowed_peak_rms_level_history #(
    parameter int HISTORY_DEPTH = wprl_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_CHANNELS  = wprl_pkg::MAX_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [14:0] i_level_db,
    input  logic [2:0]         i_channel,
    input  logic [31:0]        i_timestamp_ms,
    input  logic [31:0]        i_since_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_out_channel,
    output logic signed [14:0] o_out_level_db,
    output logic               o_last
);
    import wprl_pkg::*;
    `include "windowed_peak_rms_level_history_assert.svh"

    localparam int HW   = $clog2(HISTORY_DEPTH);
    localparam int FW   = $clog2(HISTORY_DEPTH + 1);
    localparam int RW   = FW + 1;
    localparam int LA   = $clog2(HISTORY_DEPTH * MAX_CHANNELS);
    localparam int NCAP = (MAX_CHANNELS < LANES) ? MAX_CHANNELS : LANES;

    t_state r_state, n_state;
    logic [3:0]         r_cc, n_cc;
    logic [HW-1:0]      r_head, n_head, r_idx, n_idx;
    logic [FW-1:0]      r_fill, n_fill, r_rows, n_rows;
    logic               r_rms, n_rms;
    logic [31:0]        r_since, n_since;
    logic [2:0]         r_ch, n_ch;
    logic signed [14:0] r_max [LANES];
    logic signed [14:0] n_max [LANES];
    logic [55:0]        r_sum [LANES];
    logic [55:0]        n_sum [LANES];
    logic signed [34:0] r_t, n_t;
    logic               r_zero, n_zero;
    logic [30:0]        r_m, n_m;
    logic [3:0]         r_step, n_step;
    logic [55:0]        r_dq, n_dq;
    logic [RW-1:0]      r_dr, n_dr;
    logic [5:0]         r_cnt, n_cnt;
    logic signed [22:0] r_lg, n_lg;
    logic signed [45:0] r_prod, n_prod;
    logic [2:0]         r_och, n_och;
    logic signed [14:0] r_olev, n_olev;
    logic               r_olast, n_olast;

    logic [3:0]         w_n;
    logic               w_acc, w_app_ok, w_row_end, w_ch_last;
    t_action            w_act;
    logic               w_lev_we, w_time_we;
    logic [LA-1:0]      w_lev_waddr, w_lev_raddr;
    logic signed [14:0] w_lev;
    logic [31:0]        w_time;
    logic signed [14:0] w_dc;
    logic [61:0]        w_emul, w_sq;
    logic [30:0]        w_mexp;
    logic signed [10:0] w_k;
    logic signed [11:0] w_sh, w_s;
    logic [43:0]        w_pow;
    logic [RW-1:0]      w_rs, w_rows_x;
    logic [5:0]         w_top;
    logic signed [6:0]  w_e;
    logic signed [47:0] w_round;
    logic signed [15:0] w_v;

    // effective channel count and request decode
    assign w_n       = (r_cc > 4'(NCAP)) ? 4'(NCAP) : r_cc;
    assign w_act     = t_action'(i_action);
    assign w_acc     = i_valid && o_ready;
    assign w_app_ok  = w_acc && (w_act == ACT_APPEND) && ({1'b0, i_channel} < w_n);
    assign w_row_end = ({1'b0, i_channel} == w_n - 4'd1);
    assign w_ch_last = ({1'b0, r_ch} == w_n - 4'd1);

    // memory ports
    assign w_lev_we    = w_app_ok;
    assign w_time_we   = w_app_ok && w_row_end;
    assign w_lev_waddr = LA'(LA'(r_head) * LA'(MAX_CHANNELS) + LA'(i_channel));
    assign w_lev_raddr = LA'(LA'(r_idx) * LA'(MAX_CHANNELS) + LA'(r_ch));

    wprl_ram #(.WIDTH(15), .DEPTH(HISTORY_DEPTH * MAX_CHANNELS)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (w_lev_we),
        .i_waddr (w_lev_waddr),
        .i_wdata (i_level_db),
        .i_raddr (w_lev_raddr),
        .o_rdata (w_lev)
    );

    wprl_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_time_we),
        .i_waddr (r_head),
        .i_wdata (i_timestamp_ms),
        .i_raddr (r_idx),
        .o_rdata (w_time)
    );

    // power expansion step and final scaling shift
    assign w_dc   = (w_lev > LEVEL_CEIL) ? LEVEL_CEIL : w_lev;
    assign w_emul = 62'(r_m) * 62'(exp_frac(r_step));
    assign w_mexp = 31'((w_emul + (62'd1 << 29)) >> 30);
    assign w_k    = r_t[34:24];
    assign w_sh   = 12'(w_k) - 12'sd6;
    assign w_s    = -w_sh;

    always_comb begin
        if (r_zero) begin
            w_pow = '0;
        end else if (w_sh >= 12'sd0) begin
            w_pow = 44'(r_m) << w_sh[3:0];
        end else if (w_s >= 12'sd40) begin
            w_pow = '0;
        end else begin
            w_pow = 44'((45'(r_m) + (45'd1 << (w_s[5:0] - 6'd1))) >> w_s[5:0]);
        end
    end

    // divider, normalize, log and rounding helpers
    assign w_rs     = {r_dr[RW-2:0], r_dq[55]};
    assign w_rows_x = RW'(r_rows);
    assign w_top    = 6'd55 - r_cnt;
    assign w_e      = $signed({1'b0, w_top}) - 7'sd24;
    assign w_sq     = 62'(r_m) * 62'(r_m);
    assign w_round  = 48'(r_prod) + (48'sd1 <<< 31);
    assign w_v      = w_round[47:32];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (w_act == ACT_QMAX || w_act == ACT_QRMS) && w_n != 4'd0) begin
                    n_state = S_TREAD;
                end
            end
            S_TREAD: n_state = (r_rows == r_fill) ? S_RES : S_TDATA;
            S_TDATA: n_state = (w_time < r_since) ? S_RES : S_LREAD;
            S_LREAD: n_state = S_LDATA;
            S_LDATA: n_state = S_EXP;
            S_EXP:   n_state = (r_step == 4'd9) ? S_SHIFT : S_EXP;
            S_SHIFT: n_state = w_ch_last ? S_TREAD : S_LREAD;
            S_RES: begin
                if (!r_rms || r_rows == '0) begin
                    n_state = S_OWAIT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   n_state = (r_cnt == 6'd55) ? S_NORM : S_DIV;
            S_NORM: begin
                if (r_dq == '0) begin
                    n_state = S_OWAIT;
                end else if (r_dq[55]) begin
                    n_state = S_LOG;
                end
            end
            S_LOG:   n_state = (r_step == 4'd15) ? S_MUL : S_LOG;
            S_MUL:   n_state = S_FIN;
            S_FIN:   n_state = S_OWAIT;
            S_OWAIT: begin
                if (i_ready) begin
                    n_state = w_ch_last ? S_IDLE : S_RES;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and output register next values
    always_comb begin
        n_cc    = r_cc;
        n_head  = r_head;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_rows  = r_rows;
        n_rms   = r_rms;
        n_since = r_since;
        n_ch    = r_ch;
        n_max   = r_max;
        n_sum   = r_sum;
        n_t     = r_t;
        n_zero  = r_zero;
        n_m     = r_m;
        n_step  = r_step;
        n_dq    = r_dq;
        n_dr    = r_dr;
        n_cnt   = r_cnt;
        n_lg    = r_lg;
        n_prod  = r_prod;
        n_och   = r_och;
        n_olev  = r_olev;
        n_olast = r_olast;

        unique case (r_state)
            S_IDLE: begin
                // append advances the ring on the last channel
                if (w_app_ok && w_row_end) begin
                    n_head = (r_head == HW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    if (r_fill != FW'(HISTORY_DEPTH)) begin
                        n_fill = r_fill + 1'b1;
                    end
                end
                // query start
                n_rows  = '0;
                n_idx   = (r_head == '0) ? HW'(HISTORY_DEPTH - 1) : r_head - 1'b1;
                n_rms   = (w_act == ACT_QRMS);
                n_since = i_since_ms;
                n_ch    = '0;
                for (int c = 0; c < LANES; c++) begin
                    n_max[c] = LEVEL_FLOOR;
                    n_sum[c] = '0;
                end
            end
            S_TREAD: n_ch = '0;
            S_TDATA: n_ch = '0;
            S_LREAD: ;
            S_LDATA: begin
                if (w_lev > r_max[r_ch]) begin
                    n_max[r_ch] = w_lev;
                end
                n_t    = 35'(w_dc) * LOG2_TEN_Q24;
                n_zero = (w_lev <= LEVEL_FLOOR);
                n_m    = 31'd1073741824;
                n_step = '0;
            end
            S_EXP: begin
                if (r_t[5'd23 - 5'(r_step)]) begin
                    n_m = w_mexp;
                end
                n_step = r_step + 4'd1;
            end
            S_SHIFT: begin
                n_sum[r_ch] = r_sum[r_ch] + 56'(w_pow);
                if (w_ch_last) begin
                    n_rows = r_rows + 1'b1;
                    n_idx  = (r_idx == '0) ? HW'(HISTORY_DEPTH - 1) : r_idx - 1'b1;
                    n_ch   = '0;
                end else begin
                    n_ch = r_ch + 3'd1;
                end
            end
            S_RES: begin
                n_och   = r_ch;
                n_olast = w_ch_last;
                if (!r_rms) begin
                    n_olev = (r_max[r_ch] > LEVEL_CEIL) ? LEVEL_CEIL : r_max[r_ch];
                end else begin
                    n_olev = LEVEL_FLOOR;
                end
                n_dq  = r_sum[r_ch] + 56'(r_rows >> 1);
                n_dr  = '0;
                n_cnt = '0;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (w_rs >= w_rows_x) begin
                    n_dr = w_rs - w_rows_x;
                    n_dq = {r_dq[54:0], 1'b1};
                end else begin
                    n_dr = w_rs;
                    n_dq = {r_dq[54:0], 1'b0};
                end
                n_cnt = (r_cnt == 6'd55) ? 6'd0 : r_cnt + 6'd1;
            end
            S_NORM: begin
                // shift left until the top bit is set
                if (r_dq != '0 && !r_dq[55]) begin
                    n_dq  = r_dq << 1;
                    n_cnt = r_cnt + 6'd1;
                end
                n_lg   = {w_e, 16'd0};
                n_m    = r_dq[55:25];
                n_step = '0;
            end
            S_LOG: begin
                // one fraction bit of log2 per squaring
                if (w_sq[61]) begin
                    n_lg = r_lg | (23'sd1 <<< (4'd15 - r_step));
                    n_m  = w_sq[61:31];
                end else begin
                    n_m  = w_sq[60:30];
                end
                n_step = r_step + 4'd1;
            end
            S_MUL: n_prod = 46'(r_lg) * DB16_Q16;
            S_FIN: begin
                if (w_v < 16'(LEVEL_FLOOR)) begin
                    n_olev = LEVEL_FLOOR;
                end else if (w_v > 16'(LEVEL_CEIL)) begin
                    n_olev = LEVEL_CEIL;
                end else begin
                    n_olev = w_v[14:0];
                end
            end
            S_OWAIT: begin
                if (i_ready && !w_ch_last) begin
                    n_ch = r_ch + 3'd1;
                end
            end
            default: ;
        endcase

        // register write clears the history
        if (i_cfg_we) begin
            n_cc   = i_cfg_wdata;
            n_head = '0;
            n_fill = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cc    <= '0;
            r_head  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_cc    <= n_cc;
            r_head  <= n_head;
            r_fill  <= n_fill;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_rows  <= n_rows;
        r_rms   <= n_rms;
        r_since <= n_since;
        r_ch    <= n_ch;
        r_max   <= n_max;
        r_sum   <= n_sum;
        r_t     <= n_t;
        r_zero  <= n_zero;
        r_m     <= n_m;
        r_step  <= n_step;
        r_dq    <= n_dq;
        r_dr    <= n_dr;
        r_cnt   <= n_cnt;
        r_lg    <= n_lg;
        r_prod  <= n_prod;
        r_och   <= n_och;
        r_olev  <= n_olev;
        r_olast <= n_olast;
    end

    // ports
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_OWAIT);
    assign o_out_channel  = r_och;
    assign o_out_level_db = r_olev;
    assign o_last         = r_olast;

    // checks
    `WPRL_AST_IMP(a_fill_bound, 1'b1, r_fill <= FW'(HISTORY_DEPTH))
    `WPRL_AST_IMP(a_rows_bound, r_state != S_IDLE, r_rows <= r_fill)
    `WPRL_AST_NXT(a_query_start, w_acc && (w_act == ACT_QMAX || w_act == ACT_QRMS) && w_n != 4'd0, r_state == S_TREAD)
    `WPRL_AST_NXT(a_last_done, o_valid && i_ready && o_last, r_state == S_IDLE)
endmodule

@@ dv/tb.sv @@
// self-checking testbench for windowed_peak_rms_level_history
// depends on wprl_pkg and the rtl of the level history block
`timescale 1ns / 1ps
module tb;
    import wprl_pkg::*;

    localparam int DEPTH       = 256;
    localparam int LANE_MAX    = 8;
    localparam int QUIET_LIMIT = 200000;

    typedef struct {
        logic [2:0]         chan;
        logic signed [14:0] level;
        logic               last;
    } t_level_result;

    // tracks history contents and predicts the per-channel query results
    class level_scoreboard;
        int            level_mem[DEPTH * LANE_MAX];
        bit            written[DEPTH * LANE_MAX];
        logic [31:0]   row_time[DEPTH];
        int            head;
        int            fill;
        int            active;
        t_level_result pending[$];
        int            errors;
        int            checked;
        int            queries;
        int            appends;
        longint unsigned frac_step[10];

        function new();
            head = 0;
            fill = 0;
            active = 0;
            errors = 0;
            checked = 0;
            queries = 0;
            appends = 0;
            frac_step = '{1518500250, 1276901417, 1170923762, 1121280435, 1097253708,
                          1085434106, 1079572136, 1076653033, 1075196443, 1074468888};
        endfunction

        function void set_channel_count(logic [3:0] v);
            active = (v > LANE_MAX) ? LANE_MAX : int'(v);
            head = 0;
            fill = 0;
        endfunction

        // linear power in q24 of a level in 1/16 dB
        function longint unsigned db_to_power(int d);
            longint t;
            longint k;
            longint sh;
            longint unsigned frac;
            longint unsigned m;
            if (d <= -16000) return 0;
            if (d > 960) d = 960;
            t = longint'(d) * 64'sd348329;
            k = t >>> 24;
            frac = longint'(t - (k <<< 24)) >> 14;
            m = 64'd1 << 30;
            for (int i = 0; i < 10; i++) begin
                if (frac[9 - i]) m = (m * frac_step[i] + (64'd1 << 29)) >> 30;
            end
            sh = k - 6;
            if (sh >= 0) return m << sh;
            if (-sh >= 40) return 0;
            return (m + (64'd1 << (-sh - 1))) >> (-sh);
        endfunction

        // level in 1/16 dB of a q24 mean power
        function int power_to_db(longint unsigned p);
            int top;
            longint unsigned m;
            longint lg;
            longint v;
            top = 0;
            if (p == 0) return -16000;
            for (int i = 0; i < 64; i++) begin
                if (p[i]) top = i;
            end
            m = (top >= 30) ? (p >> (top - 30)) : (p << (30 - top));
            lg = longint'(top - 24) * 65536;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    lg += longint'(1) << (15 - i);
                    m >>= 1;
                end
            end
            v = (lg * 64'sd3156528 + (64'sd1 <<< 31)) >>> 32;
            if (v < -16000) v = -16000;
            if (v > 960) v = 960;
            return int'(v);
        endfunction

        function bit row_complete();
            for (int c = 0; c < active - 1; c++) begin
                if (!written[head * LANE_MAX + c]) return 0;
            end
            return 1;
        endfunction

        function void note_request(t_action act, logic signed [14:0] lvl, logic [2:0] ch,
                                   logic [31:0] ts, logic [31:0] since);
            longint unsigned power_sum[LANE_MAX];
            int peak[LANE_MAX];
            int rows;
            int idx;
            int r;
            t_level_result res;
            if (act == ACT_APPEND) begin
                appends++;
                if (int'(ch) >= active) return;
                level_mem[head * LANE_MAX + ch] = lvl;
                written[head * LANE_MAX + ch] = 1;
                if (int'(ch) == active - 1) begin
                    row_time[head] = ts;
                    head = (head + 1) % DEPTH;
                    if (fill < DEPTH) fill++;
                end
                return;
            end
            if (act == ACT_NONE || active == 0) return;
            queries++;
            for (int c = 0; c < LANE_MAX; c++) begin
                power_sum[c] = 0;
                peak[c] = -16000;
            end
            rows = 0;
            idx = (head + DEPTH - 1) % DEPTH;
            // walk newest to oldest until a row is older than the window
            for (int i = 0; i < fill; i++) begin
                if (row_time[idx] < since) break;
                for (int c = 0; c < active; c++) begin
                    if (level_mem[idx * LANE_MAX + c] > peak[c])
                        peak[c] = level_mem[idx * LANE_MAX + c];
                    power_sum[c] += db_to_power(level_mem[idx * LANE_MAX + c]);
                end
                rows++;
                idx = (idx + DEPTH - 1) % DEPTH;
            end
            for (int c = 0; c < active; c++) begin
                if (act == ACT_QMAX) begin
                    r = (peak[c] > 960) ? 960 : peak[c];
                end else if (rows == 0) begin
                    r = -16000;
                end else begin
                    r = power_to_db((power_sum[c] + rows / 2) / rows);
                end
                res.chan = c[2:0];
                res.level = r[14:0];
                res.last = (c == active - 1);
                pending.push_back(res);
            end
        endfunction

        function void check_result(logic [2:0] ch, logic signed [14:0] lvl, logic last);
            t_level_result want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: channel %0d level %0d", ch, lvl);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (ch !== want.chan) begin
                $error("out_channel: expected %0d, actual %0d", want.chan, ch);
                errors++;
            end
            if (lvl !== want.level) begin
                $error("out_level_db: expected %0d, actual %0d", want.level, lvl);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [3:0]         i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = '0;
    logic signed [14:0] i_level_db = '0;
    logic [2:0]         i_channel = '0;
    logic [31:0]        i_timestamp_ms = '0;
    logic [31:0]        i_since_ms = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_out_channel;
    logic signed [14:0] o_out_level_db;
    logic               o_last;

    level_scoreboard sb = new();
    bit              calm = 0;
    int              stall_left = 0;
    int              quiet = 0;
    logic [31:0]     now_ms = 32'd1000;

    windowed_peak_rms_level_history uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_level_db     (i_level_db),
        .i_channel      (i_channel),
        .i_timestamp_ms (i_timestamp_ms),
        .i_since_ms     (i_since_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_channel  (o_out_channel),
        .o_out_level_db (o_out_level_db),
        .o_last         (o_last)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_out_channel, o_out_level_db, o_last);
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                quiet <= 0;
            end else if (quiet + 1 >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    // one request, with an optional random gap ahead of it
    task automatic send_req(t_action act, logic signed [14:0] lvl, logic [2:0] ch,
                            logic [31:0] ts, logic [31:0] since);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_level_db <= lvl;
        i_channel <= ch;
        i_timestamp_ms <= ts;
        i_since_ms <= since;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(act, lvl, ch, ts, since);
    endtask

    // channel count write once the block has drained
    task automatic program_channels(logic [3:0] v);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_channel_count(v);
    endtask

    function automatic logic signed [14:0] pick_level();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 15'($urandom());
        if (r == 1) return -15'sd16000;
        if (r == 2) return 15'sd960;
        return 15'($urandom_range(0, 16960)) - 15'sd16000;
    endfunction

    function automatic logic [31:0] pick_since();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF;
            default: return now_ms - $urandom_range(0, 1500);
        endcase
    endfunction

    // full row, channels in order, last one stamps it
    task automatic append_row(logic [31:0] ts);
        for (int c = 0; c < sb.active; c++) begin
            send_req(ACT_APPEND, pick_level(), c[2:0], ts, $urandom());
        end
    endtask

    task automatic random_phase(int items);
        int done;
        int ch;
        done = 0;
        while (done < items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    now_ms = ($urandom_range(0, 15) == 0) ? $urandom()
                                                          : now_ms + $urandom_range(1, 200);
                    append_row(now_ms);
                    done += (sb.active > 0) ? sb.active : 1;
                end
                6: begin
                    // stray append, never closing a row with holes in it
                    ch = $urandom_range(0, 7);
                    if (sb.active > 0 && ch == sb.active - 1 && !sb.row_complete()) begin
                        for (int c = sb.active - 2; c >= 0; c--) begin
                            if (!sb.written[sb.head * LANE_MAX + c]) ch = c;
                        end
                    end
                    send_req(ACT_APPEND, pick_level(), ch[2:0], $urandom(), $urandom());
                    done++;
                end
                7, 8: begin
                    send_req($urandom_range(0, 1) ? ACT_QMAX : ACT_QRMS, 15'($urandom()),
                             3'($urandom()), $urandom(), pick_since());
                    done++;
                end
                default: begin
                    send_req(ACT_NONE, 15'($urandom()), 3'($urandom()), $urandom(),
                             $urandom());
                    done++;
                end
            endcase
        end
    endtask

    initial begin
        logic [3:0] counts[7];
        counts = '{4'd3, 4'd1, 4'd15, 4'd6, 4'd0, 4'd2, 4'd8};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled block: nothing stored, nothing returned
        send_req(ACT_APPEND, 15'sd100, 3'd0, 32'd5, 32'd0);
        send_req(ACT_QMAX, 15'sd0, 3'd0, 32'd0, 32'd0);
        send_req(ACT_QRMS, 15'sd0, 3'd7, 32'd0, 32'd0);

        // directed: empty window, extremes, saturation, unused action
        // 15'sh4000 is the most negative level
        program_channels(4'd8);
        send_req(ACT_QRMS, 15'sd0, 3'd0, 32'd0, 32'd0);
        send_req(ACT_QMAX, 15'sd0, 3'd0, 32'd0, 32'd0);
        send_req(ACT_APPEND, -15'sd16000, 3'd0, 32'd0, 32'd0);
        send_req(ACT_APPEND, 15'sh4000, 3'd1, 32'd0, 32'd0);
        send_req(ACT_APPEND, 15'sd960, 3'd2, 32'd0, 32'd0);
        send_req(ACT_APPEND, 15'sd16383, 3'd3, 32'd0, 32'd0);
        send_req(ACT_APPEND, 15'sd0, 3'd4, 32'd0, 32'd0);
        send_req(ACT_APPEND, -15'sd1, 3'd5, 32'd0, 32'd0);
        send_req(ACT_APPEND, -15'sd8000, 3'd6, 32'd0, 32'd0);
        send_req(ACT_APPEND, 15'sd500, 3'd7, 32'd0, 32'hFFFF_FFFF);
        send_req(ACT_QMAX, 15'sd0, 3'd0, 32'd0, 32'd0);
        send_req(ACT_QRMS, 15'sd0, 3'd0, 32'd0, 32'd0);
        send_req(ACT_QRMS, 15'sd0, 3'd0, 32'd0, 32'hFFFF_FFFF);
        append_row(32'hFFFF_FFFF);
        send_req(ACT_QMAX, 15'sd0, 3'd0, 32'd0, 32'hFFFF_FFFF);
        send_req(ACT_QRMS, 15'sd0, 3'd0, 32'd0, 32'd1);
        send_req(ACT_NONE, 15'sh4000, 3'd7, 32'hFFFF_FFFF, 32'd0);

        // random phases across channel counts, quiet handshakes at the end
        for (int p = 0; p < 7; p++) begin
            program_channels(counts[p]);
            now_ms = $urandom_range(0, 100000);
            if (p == 6) calm = 1;
            random_phase(15);
        end

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests (%0d appends, %0d queries), %0d results checked",
                 sb.appends + sb.queries, sb.appends, sb.queries, sb.checked);
        $display("over channel counts 0 to 15, with random gaps and result stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/wprl_pkg.sv
design/wprl_ram.sv
design/windowed_peak_rms_level_history.sv
dv/tb.sv
